// File: sv/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended queue package
// Command codes, word types and default sizes shared by the queue and its
// checker.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int WORD_BITS_DEFAULT = 32;

    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 5;
    localparam int CMD_BITS   = 3;

    localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_PEEK       = 3'd5;

    typedef struct packed {
        logic [CMD_BITS-1:0]          command;
        logic signed [VALUE_BITS-1:0] value_in;
    } cmd_word_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] front_value;
        logic signed [VALUE_BITS-1:0] back_value;
        logic [COUNT_BITS-1:0]        entry_count;
        logic                         is_empty;
        logic                         fault;
    } result_word_t;

endpackage

// File: sv/bounded_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended queue
// One command per clock cycle: busy is held low, so a command is taken at
// every edge where start is high. Its result word appears on result with done
// high in the next cycle, matching the registered read of the word store; the
// receiver cannot stall it. A word pushed in the same cycle as it is read is
// forwarded around the store.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue #(
    parameter int DEPTH     = bdq_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bdq_pkg::cmd_word_t   cmd,
    output logic                 done,
    output bdq_pkg::result_word_t result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 2;
    localparam int VB = bdq_pkg::VALUE_BITS;
    localparam int NB = bdq_pkg::COUNT_BITS;

    logic [WORD_BITS-1:0] word_store [DEPTH];

    logic [AW-1:0]        front_reg;
    logic [AW-1:0]        front_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 done_reg;
    logic                 fault_reg;
    logic                 fault_next;
    logic                 fwd_front_reg;
    logic                 fwd_back_reg;
    logic [WORD_BITS-1:0] wdata_reg;
    logic [WORD_BITS-1:0] rd_front_reg;
    logic [WORD_BITS-1:0] rd_back_reg;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS+VB-1:0] wide_in;
    logic [AW-1:0]        front_dec;
    logic [AW-1:0]        front_inc;
    logic [SW-1:0]        tail_sum;
    logic [AW-1:0]        tail_slot;
    logic [SW-1:0]        back_sum;
    logic [AW-1:0]        back_slot;
    logic [WORD_BITS-1:0] front_word;
    logic [WORD_BITS-1:0] back_word;
    logic [WORD_BITS+VB-1:0] wide_front;
    logic [WORD_BITS+VB-1:0] wide_back;
    logic [CW+NB-1:0]     wide_count;
    logic                 out_empty;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    assign wide_in = {{WORD_BITS{1'b0}}, cmd.value_in};
    assign wdata   = wide_in[WORD_BITS-1:0];

    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign tail_sum  = SW'(front_reg) + SW'(count_reg);
    assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        fault_next = 1'b0;
        we         = 1'b0;
        waddr      = tail_slot;
        if (accept)
        begin
            case (cmd.command)
                bdq_pkg::CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                        we         = 1'b1;
                        waddr      = front_dec;
                    end
                end
                bdq_pkg::CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        we         = 1'b1;
                    end
                end
                bdq_pkg::CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                bdq_pkg::CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                bdq_pkg::CMD_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                default:
                begin
                    front_next = front_reg;
                end
            endcase
        end
    end

    assign back_sum  = SW'(front_next) + SW'(count_next) - SW'(1);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            word_store[waddr] <= wdata;
        end
        rd_front_reg  <= word_store[front_next];
        rd_back_reg   <= word_store[back_slot];
        wdata_reg     <= wdata;
        fwd_front_reg <= we && (waddr == front_next);
        fwd_back_reg  <= we && (waddr == back_slot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            fault_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            done_reg  <= accept;
            fault_reg <= fault_next;
        end
    end

    assign front_word = fwd_front_reg ? wdata_reg : rd_front_reg;
    assign back_word  = fwd_back_reg ? wdata_reg : rd_back_reg;
    assign wide_front = {{VB{1'b0}}, front_word};
    assign wide_back  = {{VB{1'b0}}, back_word};
    assign wide_count = {{NB{1'b0}}, count_reg};
    assign out_empty  = (count_reg == '0);

    assign done               = done_reg;
    assign result.front_value = out_empty ? '0 : wide_front[VB-1:0];
    assign result.back_value  = out_empty ? '0 : wide_back[VB-1:0];
    assign result.entry_count = wide_count[NB-1:0];
    assign result.is_empty    = out_empty;
    assign result.fault       = fault_reg;

endmodule

// File: sv/bdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended queue checker
// Port-level checks on result timing and result contents, bound to the queue.
// ----------------------------------------------------------------------------
module bdq_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input bdq_pkg::cmd_word_t    cmd,
    input logic                  done,
    input bdq_pkg::result_word_t result
);

    a_done_follows_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done
    ) else $error("Accepted word gave no result in the next cycle.");

    a_no_spurious_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done
    ) else $error("Result strobe without an accepted word.");

    a_empty_values_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |-> (result.front_value == '0 && result.back_value == '0)
    ) else $error("Empty queue reported non-zero values.");

    a_clear_empties: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.command == bdq_pkg::CMD_CLEAR)
            |=> (done && result.is_empty && !result.fault)
    ) else $error("Clear did not leave an empty queue without fault.");

    a_peek_no_fault: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.command == bdq_pkg::CMD_PEEK) |=> !result.fault
    ) else $error("Peek raised a fault.");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended queue testbench
// A queue of command words feeds a clocked driver, which offers them to the
// block with random idle bursts. A clocked monitor keeps its own model of the
// circular store, works out the result word of every accepted command and
// compares the block's result words with it field by field. Directed commands
// cover the empty and full edges, extreme words and the spare codes; random
// phases then fill, drain and churn the queue.
// ----------------------------------------------------------------------------
module tb;

    localparam int QDEPTH      = bdq_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 165;

    localparam logic [bdq_pkg::CMD_BITS-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [bdq_pkg::CMD_BITS-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic signed [bdq_pkg::VALUE_BITS-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [bdq_pkg::VALUE_BITS-1:0] WORD_MIN = 32'sh8000_0000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    bdq_pkg::cmd_word_t    cmd = '0;
    logic                  done;
    bdq_pkg::result_word_t result;

    bdq_pkg::cmd_word_t    pending_cmds[$];
    bdq_pkg::result_word_t expected_results[$];

    logic signed [bdq_pkg::VALUE_BITS-1:0] model_store[QDEPTH];
    int   model_head = 0;
    int   model_held = 0;

    logic word_taken = 1'b0;
    bit   steady = 1'b0;
    int   gap_left = 0;
    int   cycles = 0;
    int   mismatches = 0;

    bounded_double_ended_queue uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bdq_pkg::result_word_t apply_command(bdq_pkg::cmd_word_t w);
        bdq_pkg::result_word_t r;
        logic                  flt;
        flt = 1'b0;
        case (w.command)
            bdq_pkg::CMD_PUSH_FRONT:
                if (model_held == QDEPTH)
                    flt = 1'b1;
                else
                begin
                    model_head = (model_head + QDEPTH - 1) % QDEPTH;
                    model_store[model_head] = w.value_in;
                    model_held++;
                end
            bdq_pkg::CMD_PUSH_BACK:
                if (model_held == QDEPTH)
                    flt = 1'b1;
                else
                begin
                    model_store[(model_head + model_held) % QDEPTH] = w.value_in;
                    model_held++;
                end
            bdq_pkg::CMD_POP_FRONT:
                if (model_held == 0)
                    flt = 1'b1;
                else
                begin
                    model_head = (model_head + 1) % QDEPTH;
                    model_held--;
                end
            bdq_pkg::CMD_POP_BACK:
                if (model_held == 0)
                    flt = 1'b1;
                else
                    model_held--;
            bdq_pkg::CMD_CLEAR:
            begin
                model_head = 0;
                model_held = 0;
            end
            default: ;
        endcase
        r = '0;
        if (model_held != 0)
        begin
            r.front_value = model_store[model_head];
            r.back_value  = model_store[(model_head + model_held - 1) % QDEPTH];
        end
        r.entry_count = model_held[bdq_pkg::COUNT_BITS-1:0];
        r.is_empty    = (model_held == 0);
        r.fault       = flt;
        return r;
    endfunction

    function automatic logic signed [bdq_pkg::VALUE_BITS-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cmd(logic [bdq_pkg::CMD_BITS-1:0] c,
                           logic signed [bdq_pkg::VALUE_BITS-1:0] v);
        bdq_pkg::cmd_word_t w;
        w.command  = c;
        w.value_in = v;
        pending_cmds.push_back(w);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Driver: offers the oldest pending command word, with random idle bursts.
    always @(negedge clk)
    begin : driver
        bdq_pkg::cmd_word_t junk;
        if (rst_n)
        begin
            if (word_taken)
                void'(pending_cmds.pop_front());
            if (gap_left == 0 && !steady && pending_cmds.size() != 0
                && $urandom_range(0, 9) == 0)
                gap_left = $urandom_range(1, 19);
            if (gap_left > 0 || pending_cmds.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                junk.command  = bdq_pkg::CMD_BITS'($urandom_range(0, 7));
                junk.value_in = $urandom;
                start <= 1'b0;
                cmd   <= junk;
            end
            else
            begin
                start <= 1'b1;
                cmd   <= pending_cmds[0];
            end
        end
    end

    // Monitor: predicts accepted commands and checks every result word.
    always @(posedge clk)
    begin : monitor
        bdq_pkg::result_word_t want;
        if (!rst_n)
            word_taken <= 1'b0;
        else
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            else
            begin
                word_taken <= start && !busy;
                if (start && !busy)
                    expected_results.push_back(apply_command(cmd));
                if (done)
                begin
                    if (expected_results.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("unexpected result word: front %0d back %0d count %0d",
                                     result.front_value, result.back_value,
                                     result.entry_count,
                                     " empty %0b fault %0b",
                                     result.is_empty, result.fault);
                    end
                    else
                    begin
                        want = expected_results.pop_front();
                        if (result.front_value !== want.front_value
                            || result.back_value !== want.back_value
                            || result.entry_count !== want.entry_count
                            || result.is_empty !== want.is_empty
                            || result.fault !== want.fault)
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                            begin
                                $display("mismatch: expected front %0d back %0d count %0d",
                                         want.front_value, want.back_value,
                                         want.entry_count,
                                         " empty %0b fault %0b",
                                         want.is_empty, want.fault);
                                $display("          got front %0d back %0d count %0d",
                                         result.front_value, result.back_value,
                                         result.entry_count,
                                         " empty %0b fault %0b",
                                         result.is_empty, result.fault);
                            end
                        end
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int push_pct;
        int pop_pct;
        int r;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        add_cmd(bdq_pkg::CMD_POP_FRONT, random_word());
        add_cmd(bdq_pkg::CMD_POP_BACK, random_word());
        add_cmd(bdq_pkg::CMD_PEEK, random_word());
        add_cmd(bdq_pkg::CMD_PUSH_FRONT, WORD_MAX);
        add_cmd(bdq_pkg::CMD_PUSH_BACK, WORD_MIN);
        add_cmd(CMD_SPARE_6, random_word());
        add_cmd(CMD_SPARE_7, random_word());
        add_cmd(bdq_pkg::CMD_POP_BACK, random_word());
        add_cmd(bdq_pkg::CMD_POP_BACK, random_word());
        for (int i = 0; i < QDEPTH; i++)
            add_cmd(i[0] ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT,
                    random_word());
        add_cmd(bdq_pkg::CMD_PUSH_FRONT, random_word());
        add_cmd(bdq_pkg::CMD_PUSH_BACK, random_word());
        add_cmd(bdq_pkg::CMD_CLEAR, random_word());
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 3)
                0:
                begin
                    push_pct = 70;
                    pop_pct  = 20;
                end
                1:
                begin
                    push_pct = 45;
                    pop_pct  = 45;
                end
                default:
                begin
                    push_pct = 20;
                    pop_pct  = 70;
                end
            endcase
            if (phase == PHASES - 1)
                steady = 1'b1;
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    add_cmd($urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_BACK
                                                 : bdq_pkg::CMD_PUSH_FRONT,
                            random_word());
                else if (r < push_pct + pop_pct)
                    add_cmd($urandom_range(0, 1) ? bdq_pkg::CMD_POP_BACK
                                                 : bdq_pkg::CMD_POP_FRONT,
                            random_word());
                else if (r < 97)
                    add_cmd(bdq_pkg::CMD_PEEK, random_word());
                else if (r < 98)
                    add_cmd(bdq_pkg::CMD_CLEAR, random_word());
                else
                    add_cmd($urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6,
                            random_word());
            end
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
sv/bdq_pkg.sv
sv/bounded_double_ended_queue.sv
sv/bdq_checker.sv
sim/tb.sv
